[rtl/lmaf_pkg.sv]
// lmaf_pkg: shared types and constants for the low-pass and moving-average filter
// used by lowpass_and_moving_average_filter_top and its checker
// no dependencies
package lmaf_pkg;

    // configuration registers
    localparam int unsigned ALPHA_W      = 17;
    localparam int unsigned WINLEN_W     = 7;
    localparam int unsigned CFG_DATA_W   = 17;
    localparam int unsigned CFG_IDX_W    = 1;
    localparam int unsigned ALPHA_SHIFT  = 16;

    localparam logic [ALPHA_W-1:0]  ALPHA_ONE    = 17'd65536;
    localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = 17'd25670;
    localparam logic [WINLEN_W-1:0] WINLEN_RESET = 7'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINLEN = 1'b1;

    // command carried in tuser
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LP,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

[rtl/lowpass_and_moving_average_filter_top.sv]
// lowpass_and_moving_average_filter_top: first-order low-pass and windowed average
// samples are kept in one ring memory, average by a serial restoring divider
// depends on lmaf_pkg
//
// usage
//   input stream: s_axis_tdata = {limit, sample} (sample in the low bits),
//   s_axis_tuser = command (clear when set). a clear zeroes the low-pass value,
//   ring position, fill count and running sum and produces no result.
//   output stream: m_axis_tdata = {above_limit, average, smoothed}.
//   config: write cfg_data to register cfg_index (0 alpha, 1 window length)
//   while the block is idle, one write per cycle with cfg_we.
// timing
//   a sample passes the states MUL, LP, DIV and DONE after acceptance before
//   its result is loaded into the output register; the serial divider produces
//   one quotient bit per cycle. a clear completes in the idle state and
//   s_axis_tready stays high. the next sample is accepted as soon as the
//   previous one sits in the output register; if that register is still held
//   by a stalled receiver the block waits before loading the new result.
// reset
//   rst_n clears control state, filter state and configuration registers; the
//   working and output data registers are not reset, and the ring needs no
//   clearing as only entries written since a clear or reset are read.
module lowpass_and_moving_average_filter_top #(
    parameter int unsigned WINDOW_DEPTH = 64,
    parameter int unsigned SAMPLE_WIDTH = 32
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    // slave side
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // sample, limit
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
    // command
    input  logic                                      s_axis_tuser,
    // master side
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // smoothed, average, above_limit
    output logic [((2*SAMPLE_WIDTH+8)/8)*8-1:0]       m_axis_tdata,
    // configuration
    input  logic                                      cfg_we,
    input  logic [lmaf_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [lmaf_pkg::CFG_DATA_W-1:0]           cfg_data
);
    import lmaf_pkg::*;

    localparam int unsigned SW     = SAMPLE_WIDTH;
    localparam int unsigned OUT_DW = ((2*SW+8)/8)*8;
    localparam int unsigned SUM_W  = SW + $clog2(WINDOW_DEPTH);
    localparam int unsigned FW     = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned AW     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int unsigned CW     = (FW > WINLEN_W) ? FW : WINLEN_W;
    localparam int unsigned OW     = FW + 1;
    localparam int unsigned PW     = SW + ALPHA_W + 2;
    localparam int unsigned CNT_W  = $clog2(SUM_W);

    // configuration registers
    logic [ALPHA_W-1:0]  alpha_reg;
    logic [WINLEN_W-1:0] winlen_reg;

    // filter state
    logic signed [SW-1:0]    lp_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [FW-1:0]           fill_reg;
    logic [AW-1:0]           pos_reg;

    // per-transaction working registers
    logic signed [SW-1:0]    x_reg;
    logic signed [SW-1:0]    lim_reg;
    logic signed [SW:0]      d_reg;
    logic signed [PW-1:0]    prod_reg;
    logic                    drop_reg;
    logic signed [SW-1:0]    ram_q_reg;
    logic                    neg_reg;
    logic [FW-1:0]           rem_reg;
    logic [SUM_W-1:0]        quo_reg;
    logic [CNT_W-1:0]        cnt_reg;

    // output register
    logic                    m_valid_reg;
    logic [SW-1:0]           m_smoothed_reg;
    logic [SW-1:0]           m_average_reg;
    logic                    m_above_reg;

    state_t state_reg, state_next;

    logic signed [SW-1:0] ring_mem [WINDOW_DEPTH];

    // control decode
    logic in_ready;
    logic mul_en;
    logic lp_en;
    logic div_en;
    logic done_st;

    logic s_accept;
    logic s_sample_go;
    logic s_clear_go;
    logic out_load;
    logic div_last;

    logic signed [SW-1:0]    s_sample;
    logic signed [SW-1:0]    s_limit;
    logic [CW-1:0]           wl_eff;
    logic [CW-1:0]           wl_ext;
    logic                    drop_next;
    logic [OW-1:0]           pos_ext;
    logic [OW-1:0]           fill_ext;
    logic [OW-1:0]           oldest_full;
    logic [AW-1:0]           oldest_addr;
    logic [AW-1:0]           pos_next;
    logic [FW-1:0]           fill_next;
    logic signed [SUM_W-1:0] x_ext;
    logic signed [SUM_W-1:0] old_ext;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [ALPHA_W:0] alpha_eff;
    logic signed [PW-1:0]    step_full;
    logic [SW+1:0]           lp_wide;
    logic [SW+1:0]           lp_sum;
    logic [SW-1:0]           lp_next;
    logic [SUM_W-1:0]        mag_next;
    logic [FW:0]             div_shift;
    logic                    div_ge;
    logic [FW:0]             div_diff;
    logic [SUM_W-1:0]        avg_full;

    assign s_sample    = $signed(s_axis_tdata[SW-1:0]);
    assign s_limit     = $signed(s_axis_tdata[2*SW-1:SW]);
    assign s_accept    = s_axis_tvalid && in_ready;
    assign s_sample_go = s_accept && (s_axis_tuser == CMD_SAMPLE);
    assign s_clear_go  = s_accept && (s_axis_tuser == CMD_CLEAR);
    assign out_load    = done_st && (!m_valid_reg || m_axis_tready);
    assign div_last    = (cnt_reg == CNT_W'(SUM_W - 1));

    // window length limited to 1..WINDOW_DEPTH
    always_comb
    begin
        wl_ext = CW'(winlen_reg);
        if (wl_ext == '0)
            wl_eff = CW'(1);
        else if (wl_ext > CW'(WINDOW_DEPTH))
            wl_eff = CW'(WINDOW_DEPTH);
        else
            wl_eff = wl_ext;
    end

    assign drop_next = (CW'(fill_reg) >= wl_eff);

    // oldest stored entry sits fill_reg places behind the write position
    always_comb
    begin
        pos_ext  = OW'(pos_reg);
        fill_ext = OW'(fill_reg);
        if (pos_ext >= fill_ext)
            oldest_full = pos_ext - fill_ext;
        else
            oldest_full = pos_ext + OW'(WINDOW_DEPTH) - fill_ext;
    end

    assign oldest_addr = oldest_full[AW-1:0];
    assign pos_next    = (pos_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : pos_reg + AW'(1);
    assign fill_next   = drop_reg ? fill_reg : fill_reg + FW'(1);

    // running sum update once the oldest entry has been read
    assign x_ext    = {{(SUM_W-SW){x_reg[SW-1]}}, x_reg};
    assign old_ext  = {{(SUM_W-SW){ram_q_reg[SW-1]}}, ram_q_reg};
    assign sum_next = sum_reg - (drop_reg ? old_ext : SUM_W'(0)) + x_ext;

    assign alpha_eff = (alpha_reg > ALPHA_ONE) ? {1'b0, ALPHA_ONE} : {1'b0, alpha_reg};

    // low-pass add with saturation to the sample range
    always_comb
    begin
        step_full = prod_reg >>> ALPHA_SHIFT;
        lp_wide   = (SW+2)'(lp_reg);
        lp_sum    = lp_wide + step_full[SW+1:0];
        if ((lp_sum[SW+1] == lp_sum[SW]) && (lp_sum[SW] == lp_sum[SW-1]))
            lp_next = lp_sum[SW-1:0];
        else if (lp_sum[SW+1])
            lp_next = {1'b1, {(SW-1){1'b0}}};
        else
            lp_next = {1'b0, {(SW-1){1'b1}}};
    end

    assign mag_next = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    // one restoring division step
    always_comb
    begin
        div_shift = {rem_reg, quo_reg[SUM_W-1]};
        div_ge    = (div_shift >= {1'b0, fill_reg});
        div_diff  = div_shift - {1'b0, fill_reg};
    end

    assign avg_full = neg_reg ? (~quo_reg + SUM_W'(1)) : quo_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_sample_go)
                    state_next = ST_MUL;
            end
            ST_MUL:  state_next = ST_LP;
            ST_LP:   state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state decode
    always_comb
    begin
        in_ready = 1'b0;
        mul_en   = 1'b0;
        lp_en    = 1'b0;
        div_en   = 1'b0;
        done_st  = 1'b0;
        case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_MUL:  mul_en   = 1'b1;
            ST_LP:   lp_en    = 1'b1;
            ST_DIV:  div_en   = 1'b1;
            ST_DONE: done_st  = 1'b1;
            default: in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg  <= ALPHA_RESET;
            winlen_reg <= WINLEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ALPHA:  alpha_reg  <= cfg_data[ALPHA_W-1:0];
                CFG_WINLEN: winlen_reg <= cfg_data[WINLEN_W-1:0];
                default:    alpha_reg  <= alpha_reg;
            endcase
        end
    end

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_reg   <= '0;
            sum_reg  <= '0;
            fill_reg <= '0;
            pos_reg  <= '0;
        end
        else if (s_clear_go)
        begin
            lp_reg   <= '0;
            sum_reg  <= '0;
            fill_reg <= '0;
            pos_reg  <= '0;
        end
        else
        begin
            if (mul_en)
            begin
                sum_reg  <= sum_next;
                fill_reg <= fill_next;
                pos_reg  <= pos_next;
            end
            if (lp_en)
                lp_reg <= lp_next;
        end
    end

    // ring memory: read the oldest entry on acceptance, write the new sample after
    always_ff @(posedge clk)
    begin
        if (mul_en)
            ring_mem[pos_reg] <= x_reg;
        if (s_sample_go)
            ram_q_reg <= ring_mem[oldest_addr];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (s_sample_go)
        begin
            x_reg    <= s_sample;
            lim_reg  <= s_limit;
            d_reg    <= (SW+1)'(s_sample) - (SW+1)'(lp_reg);
            drop_reg <= drop_next;
        end
        if (mul_en)
            prod_reg <= PW'(d_reg) * PW'(alpha_eff);
        if (lp_en)
        begin
            neg_reg <= sum_reg[SUM_W-1];
            quo_reg <= mag_next;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (div_en)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], div_ge};
            rem_reg <= div_ge ? div_diff[FW-1:0] : div_shift[FW-1:0];
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (out_load)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_smoothed_reg <= lp_reg;
            m_average_reg  <= avg_full[SW-1:0];
            m_above_reg    <= (lp_reg > lim_reg);
        end
    end

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_DW'({m_above_reg, m_average_reg, m_smoothed_reg});

endmodule

[rtl/lmaf_checker.sv]
// lmaf_checker: port-level assertions for lowpass_and_moving_average_filter_top
// bound to the top level below; depends on lmaf_pkg
module lmaf_checker #(
    parameter int unsigned SAMPLE_WIDTH = 32
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                s_axis_tuser,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [((2*SAMPLE_WIDTH+8)/8)*8-1:0] m_axis_tdata
);
    import lmaf_pkg::*;

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // a clear transaction produces no result and the input stays open
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_CLEAR) |=> s_axis_tready)
        else $error("input closed after clear");

    // a sample transaction keeps the input closed while it is worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_SAMPLE) |=> !s_axis_tready)
        else $error("input open while sample in progress");

    // a new result only appears as the block finishes a sample
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready && $past(!s_axis_tready))
        else $error("result without sample in progress");

endmodule

bind lowpass_and_moving_average_filter_top lmaf_checker #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_lmaf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
